// File: hw/rtl/ptua_pkg.sv
// Shared types and constants for the peer table with aging.
package ptua_pkg;

    localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

    localparam logic [1:0] OUT_UPDATED  = 2'd0;
    localparam logic [1:0] OUT_INSERTED = 2'd1;
    localparam logic [1:0] OUT_DROPPED  = 2'd2;

    typedef logic [3:0] t_pc;

    localparam t_pc STEP_IDLE     = 4'd0;
    localparam t_pc STEP_SCAN_CHK = 4'd1;
    localparam t_pc STEP_SCAN_CMP = 4'd2;
    localparam t_pc STEP_HIT      = 4'd3;
    localparam t_pc STEP_NEW      = 4'd4;
    localparam t_pc STEP_AGE_CHK  = 4'd5;
    localparam t_pc STEP_AGE_CMP  = 4'd6;
    localparam t_pc STEP_SET_CNT  = 4'd7;
    localparam t_pc STEP_PLACE    = 4'd8;
    localparam t_pc STEP_INSERT   = 4'd9;
    localparam t_pc STEP_DROP     = 4'd10;
    localparam t_pc STEP_OUT      = 4'd11;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_IN_VALID = 3'd2,
        COND_I_END    = 3'd3,
        COND_KEY_MISS = 3'd4,
        COND_NOT_FULL = 3'd5,
        COND_FULL     = 3'd6,
        COND_OUT_FREE = 3'd7
    } t_cond;

    // One microcode word
    typedef struct packed {
        t_cond cond;
        logic  hold;        // stay on this step while the condition is false
        t_pc   target;
        logic  accept;
        logic  clr_i;
        logic  clr_keep;
        logic  inc_i;
        logic  inc_i_miss;
        logic  wr_hit;
        logic  keep_wr;
        logic  set_cnt;
        logic  insert;
        logic  res_upd;
        logic  res_drop;
        logic  load_out;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic i_end;
        logic key_miss;
        logic not_full;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic [55:0]        key;
        logic signed [7:0]  strength;
        logic [31:0]        seen;
    } t_entry;

endpackage

// File: hw/rtl/ptua_if.sv
// Sighting and result channel interfaces.
interface ptua_in_if;
    logic               valid;
    logic               ready;
    logic [47:0]        device_address;
    logic [7:0]         address_kind;
    logic signed [7:0]  signal_strength;
    logic [31:0]        now_ms;

    modport source (output valid, device_address, address_kind, signal_strength, now_ms,
                    input ready);
    modport sink   (input valid, device_address, address_kind, signal_strength, now_ms,
                    output ready);
endinterface

interface ptua_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] outcome;
    logic [3:0] slot;
    logic [4:0] entry_count;

    modport source (output valid, outcome, slot, entry_count, input ready);
    modport sink   (input valid, outcome, slot, entry_count, output ready);
endinterface

// File: hw/rtl/ptua_useq.sv
// Microcode ROM, step counter and jump logic.
module ptua_useq
    import ptua_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output t_pc   o_pc
);

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl cw;
    logic  taken;

    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl w;
        w = '0;
        case (pc)
            STEP_IDLE: begin
                w.cond = COND_IN_VALID; w.target = STEP_SCAN_CHK; w.hold = 1'b1;
                w.accept = 1'b1; w.clr_i = 1'b1;
            end
            STEP_SCAN_CHK: begin
                w.cond = COND_I_END; w.target = STEP_NEW;
            end
            STEP_SCAN_CMP: begin
                w.cond = COND_KEY_MISS; w.target = STEP_SCAN_CHK; w.inc_i_miss = 1'b1;
            end
            STEP_HIT: begin
                w.cond = COND_ALWAYS; w.target = STEP_OUT;
                w.wr_hit = 1'b1; w.res_upd = 1'b1;
            end
            STEP_NEW: begin
                w.cond = COND_NOT_FULL; w.target = STEP_INSERT;
                w.clr_i = 1'b1; w.clr_keep = 1'b1;
            end
            STEP_AGE_CHK: begin
                w.cond = COND_I_END; w.target = STEP_SET_CNT;
            end
            STEP_AGE_CMP: begin
                w.cond = COND_ALWAYS; w.target = STEP_AGE_CHK;
                w.keep_wr = 1'b1; w.inc_i = 1'b1;
            end
            STEP_SET_CNT: begin
                w.cond = COND_NEVER; w.set_cnt = 1'b1;
            end
            STEP_PLACE: begin
                w.cond = COND_FULL; w.target = STEP_DROP;
            end
            STEP_INSERT: begin
                w.cond = COND_ALWAYS; w.target = STEP_OUT; w.insert = 1'b1;
            end
            STEP_DROP: begin
                w.cond = COND_NEVER; w.res_drop = 1'b1;
            end
            STEP_OUT: begin
                w.cond = COND_OUT_FREE; w.target = STEP_IDLE; w.hold = 1'b1;
                w.load_out = 1'b1;
            end
            default: begin
                w.cond = COND_ALWAYS; w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    always_comb begin
        cw = ucode(r_pc);
        case (cw.cond)
            COND_NEVER:    taken = 1'b0;
            COND_ALWAYS:   taken = 1'b1;
            COND_IN_VALID: taken = i_stat.in_valid;
            COND_I_END:    taken = i_stat.i_end;
            COND_KEY_MISS: taken = i_stat.key_miss;
            COND_NOT_FULL: taken = i_stat.not_full;
            COND_FULL:     taken = !i_stat.not_full;
            COND_OUT_FREE: taken = i_stat.out_free;
            default:       taken = 1'b1;
        endcase
        if (taken) begin
            n_pc = cw.target;
        end else if (cw.hold) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = cw;
    assign o_pc   = r_pc;

endmodule

// File: hw/rtl/ptua_dpath.sv
// Table memory, index and count registers, compare and age logic, result register.
module ptua_dpath
    import ptua_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  t_ctrl         i_ctrl,
    output t_stat         o_stat,
    output logic [CW-1:0] o_cnt,
    ptua_in_if.sink       i_in,
    ptua_out_if.source    o_out
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd;

    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_keep;
    logic [31:0]        r_timeout;
    logic [55:0]        r_key;
    logic signed [7:0]  r_str;
    logic [31:0]        r_now;

    logic [1:0] r_res_outcome;
    logic [3:0] r_res_slot;
    logic [4:0] r_res_count;

    logic       r_ov;
    logic [1:0] r_o_outcome;
    logic [3:0] r_o_slot;
    logic [4:0] r_o_count;

    logic       accept;
    logic       out_free;
    logic       key_miss;
    logic       fresh;
    logic [31:0] age;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;

    assign accept   = i_ctrl.accept && i_in.valid;
    assign out_free = !r_ov || o_out.ready;
    assign key_miss = r_rd.key != r_key;
    assign age      = r_now - r_rd.seen;        // wraps modulo 2^32
    assign fresh    = age < r_timeout;

    assign o_stat.in_valid = i_in.valid;
    assign o_stat.i_end    = r_i >= r_cnt;
    assign o_stat.key_miss = key_miss;
    assign o_stat.not_full = r_cnt < CW'(MAX_ENTRIES);
    assign o_stat.out_free = out_free;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_i[IW-1:0];
        wr_data = '{key: r_key, strength: r_str, seen: r_now};
        if (i_ctrl.wr_hit) begin
            wr_en = 1'b1;
        end else if (i_ctrl.keep_wr) begin
            // survivors slide down towards slot 0
            wr_en   = fresh;
            wr_addr = r_keep[IW-1:0];
            wr_data = r_rd;
        end else if (i_ctrl.insert) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[r_i[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_cnt     <= '0;
            r_i       <= '0;
            r_keep    <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_ctrl.clr_i) begin
                r_i <= '0;
            end else if (i_ctrl.inc_i || (i_ctrl.inc_i_miss && key_miss)) begin
                r_i <= r_i + CW'(1);
            end
            if (i_ctrl.clr_keep) begin
                r_keep <= '0;
            end else if (i_ctrl.keep_wr && fresh) begin
                r_keep <= r_keep + CW'(1);
            end
            if (i_ctrl.set_cnt) begin
                r_cnt <= r_keep;
            end else if (i_ctrl.insert) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_ctrl.load_out && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= {i_in.address_kind, i_in.device_address};
            r_str <= i_in.signal_strength;
            r_now <= i_in.now_ms;
        end
        if (i_ctrl.res_upd) begin
            r_res_outcome <= OUT_UPDATED;
            r_res_slot    <= 4'(r_i);
            r_res_count   <= 5'(r_cnt);
        end else if (i_ctrl.insert) begin
            r_res_outcome <= OUT_INSERTED;
            r_res_slot    <= 4'(r_cnt);
            r_res_count   <= 5'(r_cnt + CW'(1));
        end else if (i_ctrl.res_drop) begin
            r_res_outcome <= OUT_DROPPED;
            r_res_slot    <= 4'd0;
            r_res_count   <= 5'(r_cnt);
        end
        if (i_ctrl.load_out && out_free) begin
            r_o_outcome <= r_res_outcome;
            r_o_slot    <= r_res_slot;
            r_o_count   <= r_res_count;
        end
    end

    assign i_in.ready        = i_ctrl.accept;
    assign o_out.valid       = r_ov;
    assign o_out.outcome     = r_o_outcome;
    assign o_out.slot        = r_o_slot;
    assign o_out.entry_count = r_o_count;
    assign o_cnt             = r_cnt;

endmodule

// File: hw/rtl/peer_table_update_with_aging_core.sv
// A beat that hits entry k scans entries 0 to k; a new key scans all N entries, and when
// the table is full it then runs aging over the table (N entries) before the append or drop.
// One result per beat; the two-step scan and compaction loops of the microcode, one
// table read each, set the pace, and a new beat is taken only once the last result is loaded.
// Reset: synchronous active low; empties the table and sets the stale timeout to 60000 ms.
// The next beat is taken while an earlier result still waits in the output register.
module peer_table_update_with_aging_core
    import ptua_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    ptua_in_if.sink     i_in,
    ptua_out_if.source  o_out
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_ctrl         w_ctrl;
    t_stat         w_stat;
    t_pc           w_pc;
    logic [CW-1:0] w_cnt;

    ptua_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_pc    (w_pc)
    );

    ptua_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .o_cnt       (w_cnt),
        .i_in        (i_in),
        .o_out       (o_out)
    );

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt <= CW'(MAX_ENTRIES))
        else $error("entry count above table size");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (w_pc != STEP_IDLE))
        else $error("sequencer stayed idle after taking a beat");

    a_shrink_on_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cnt < $past(w_cnt)) |-> ($past(w_pc) == STEP_SET_CNT))
        else $error("entry count fell outside compaction");
`endif

endmodule

// File: test/peer_table_update_with_aging_core_test.sv
// Self-checking testbench for the peer table with aging: directed rows, then random phases.
module peer_table_update_with_aging_core_test
    import ptua_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PEERS       = 16;
    localparam int DRAIN_CYCLES    = 4 * MAX_PEERS + 12;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int POOL_SIZE       = 24;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 145;

    typedef struct packed {
        logic [1:0] outcome;
        logic [3:0] slot;
        logic [4:0] count;
    } table_result_t;

    typedef struct {
        bit                 is_cfg;
        logic [31:0]        cfg_value;
        logic [55:0]        key;
        logic signed [7:0]  rssi;
        logic [31:0]        now;
        bit                 typed;
        table_result_t      want;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    ptua_in_if  sighting_bus ();
    ptua_out_if result_bus ();

    peer_table_update_with_aging_core #(
        .MAX_ENTRIES(MAX_PEERS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (sighting_bus),
        .o_out      (result_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted table contents
    logic [55:0]       peer_key  [MAX_PEERS];
    logic signed [7:0] peer_rssi [MAX_PEERS];
    logic [31:0]       peer_seen [MAX_PEERS];
    int                peer_count = 0;
    logic [31:0]       stale_ms = TIMEOUT_RESET;

    table_result_t pending_results [$];
    stim_row_t     directed_rows [$];
    int            fault_count = 0;
    int            cycle_count = 0;

    function automatic table_result_t apply_sighting(input logic [55:0] key,
                                                     input logic signed [7:0] rssi,
                                                     input logic [31:0] now);
        table_result_t r;
        bit            hit;
        int            keep;
        logic [31:0]   age;
        r   = '0;
        hit = 1'b0;
        for (int k = 0; k < peer_count; k++) begin
            if (!hit && peer_key[k] == key) begin
                peer_rssi[k] = rssi;
                peer_seen[k] = now;
                r.outcome    = OUT_UPDATED;
                r.slot       = 4'(k);
                hit          = 1'b1;
            end
        end
        if (!hit) begin
            // aging only runs on a miss against a full table
            if (peer_count >= MAX_PEERS) begin
                keep = 0;
                for (int k = 0; k < peer_count; k++) begin
                    age = now - peer_seen[k];
                    if (age < stale_ms) begin
                        peer_key[keep]  = peer_key[k];
                        peer_rssi[keep] = peer_rssi[k];
                        peer_seen[keep] = peer_seen[k];
                        keep++;
                    end
                end
                peer_count = keep;
            end
            if (peer_count < MAX_PEERS) begin
                peer_key[peer_count]  = key;
                peer_rssi[peer_count] = rssi;
                peer_seen[peer_count] = now;
                r.outcome             = OUT_INSERTED;
                r.slot                = 4'(peer_count);
                peer_count++;
            end else begin
                r.outcome = OUT_DROPPED;
                r.slot    = 4'd0;
            end
        end
        r.count = 5'(peer_count);
        return r;
    endfunction

    task automatic add_sighting(input logic [47:0] addr, input logic [7:0] kind,
                                input logic signed [7:0] rssi, input logic [31:0] now,
                                input bit typed, input logic [1:0] outcome,
                                input logic [3:0] slot, input logic [4:0] count);
        stim_row_t row;
        row.is_cfg       = 1'b0;
        row.cfg_value    = '0;
        row.key          = {kind, addr};
        row.rssi         = rssi;
        row.now          = now;
        row.typed        = typed;
        row.want.outcome = outcome;
        row.want.slot    = slot;
        row.want.count   = count;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [31:0] value);
        stim_row_t row;
        row           = '{default: '0};
        row.is_cfg    = 1'b1;
        row.cfg_value = value;
        directed_rows.push_back(row);
    endtask

    // Returns at a falling edge once every expected beat has been seen
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        stale_ms    = value;
    endtask

    // Entered and left at a falling edge
    task automatic drive_sighting(input logic [55:0] key, input logic signed [7:0] rssi,
                                  input logic [31:0] now, input int unsigned gap,
                                  input bit typed, input table_result_t want);
        table_result_t got;
        repeat (gap) @(negedge i_clk);
        sighting_bus.device_address  = key[47:0];
        sighting_bus.address_kind    = key[55:48];
        sighting_bus.signal_strength = rssi;
        sighting_bus.now_ms          = now;
        sighting_bus.valid           = 1'b1;
        do @(posedge i_clk); while (!sighting_bus.ready);
        got = apply_sighting(key, rssi, now);
        pending_results.push_back(typed ? want : got);
        @(negedge i_clk);
        sighting_bus.valid = 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : result_sink
        table_result_t want;
        int unsigned   stall;
        bit            sink_burst;
        result_bus.ready = 1'b0;
        sink_burst       = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                result_bus.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_bus.ready = 1'b1;
            do @(posedge i_clk); while (!result_bus.valid);
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected (outcome %0d slot %0d count %0d)",
                         $time, result_bus.outcome, result_bus.slot, result_bus.entry_count);
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                if (result_bus.outcome !== want.outcome) begin
                    $display("%0t: outcome expected %0d got %0d",
                             $time, want.outcome, result_bus.outcome);
                    fault_count++;
                end
                if (result_bus.slot !== want.slot) begin
                    $display("%0t: slot expected %0d got %0d",
                             $time, want.slot, result_bus.slot);
                    fault_count++;
                end
                if (result_bus.entry_count !== want.count) begin
                    $display("%0t: entry count expected %0d got %0d",
                             $time, want.count, result_bus.entry_count);
                    fault_count++;
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        logic [55:0] key_pool [POOL_SIZE];
        logic [31:0] phase_timeout [PHASES];
        logic [31:0] clock_ms;
        logic [31:0] now;
        logic [31:0] step_max;
        logic [55:0] key;
        int unsigned pick;
        bit          send_burst;

        i_rst_n                      = 1'b0;
        i_cfg_we                     = 1'b0;
        i_cfg_wdata                  = '0;
        sighting_bus.valid           = 1'b0;
        sighting_bus.device_address  = '0;
        sighting_bus.address_kind    = '0;
        sighting_bus.signal_strength = '0;
        sighting_bus.now_ms          = '0;
        send_burst                   = 1'b0;

        // Reset timeout holds until the first write
        add_sighting(48'h0, 8'h00, -8'sd128, 32'd0, 1, OUT_INSERTED, 4'd0, 5'd1);
        add_sighting(48'hFFFF_FFFF_FFFF, 8'hFF, 8'sd127, 32'hFFFF_FFFF,
                     1, OUT_INSERTED, 4'd1, 5'd2);
        add_sighting(48'h0, 8'h00, 8'sd5, 32'd100, 1, OUT_UPDATED, 4'd0, 5'd2);
        // same address, other kind: a distinct peer
        add_sighting(48'hFFFF_FFFF_FFFF, 8'h00, -8'sd1, 32'd200,
                     1, OUT_INSERTED, 4'd2, 5'd3);
        add_sighting(48'h8000_0000_0001, 8'h80, 8'sd0, 32'd300,
                     1, OUT_INSERTED, 4'd3, 5'd4);
        for (int i = 1; i <= 12; i++)
            add_sighting(48'h100 + 48'(i), 8'h01, -8'sd60, 32'(1000 * i),
                         1, OUT_INSERTED, 4'(3 + i), 5'(4 + i));
        // full and nothing stale yet: dropped
        add_sighting(48'h00AB_CDEF_0000, 8'h02, -8'sd40, 32'd30000,
                     1, OUT_DROPPED, 4'd0, 5'd16);
        add_sighting(48'h0, 8'h00, 8'sd127, 32'd30001, 1, OUT_UPDATED, 4'd0, 5'd16);
        // ages straddle the timeout, one entry exactly on it
        add_sighting(48'h00AB_CDEF_0000, 8'h02, -8'sd40, 32'd61000, 0, '0, '0, '0);
        add_cfg(32'd0);
        for (int j = 0; j < 3; j++)
            add_sighting(48'h200 + 48'(j), 8'h03, -8'sd70, 32'd62000, 0, '0, '0, '0);
        // zero timeout: full table empties before the append
        add_sighting(48'h300, 8'h04, -8'sd90, 32'd62000, 1, OUT_INSERTED, 4'd0, 5'd1);
        add_cfg(32'd1);
        add_sighting(48'h0, 8'h00, -8'sd20, 32'd62000, 0, '0, '0, '0);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg)
                write_timeout(directed_rows[r].cfg_value);
            else
                drive_sighting(directed_rows[r].key, directed_rows[r].rssi,
                               directed_rows[r].now, $urandom_range(0, 8),
                               directed_rows[r].typed, directed_rows[r].want);
        end

        phase_timeout = '{32'hFFFF_FFFF, 32'd1, 32'd500, 32'd60000, 32'd0,
                          32'd20000, 32'd2, 32'h8000_0000, 32'd3000, 32'd60000};
        phase_timeout[5] = $urandom_range(1, 100000);
        clock_ms = $urandom;

        for (int p = 0; p < PHASES; p++) begin
            write_timeout(phase_timeout[p]);
            for (int k = 0; k < POOL_SIZE; k++)
                key_pool[k] = 56'({$urandom, $urandom});
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else if (pick < 80 && peer_count > 0)
                    key = peer_key[$urandom_range(0, peer_count - 1)];
                else
                    key = 56'({$urandom, $urandom});
                step_max = (stale_ms < 32'd6) ? 32'd3 : stale_ms / 6;
                clock_ms += $urandom_range(0, step_max);
                pick = $urandom_range(0, 99);
                // land on or just under the stale boundary of some entry
                if (pick < 10 && peer_count > 0)
                    now = peer_seen[$urandom_range(0, peer_count - 1)] + stale_ms
                          - 32'($urandom_range(0, 1));
                else if (pick < 15)
                    now = $urandom;
                else
                    now = clock_ms;
                if ($urandom_range(0, 49) == 0) wait_drained();
                drive_sighting(key, 8'($urandom), now,
                               send_burst ? 0 : $urandom_range(0, 8), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ptua_pkg.sv
hw/rtl/ptua_if.sv
hw/rtl/ptua_useq.sv
hw/rtl/ptua_dpath.sv
hw/rtl/peer_table_update_with_aging_core.sv
test/peer_table_update_with_aging_core_test.sv
